FILE: rtl/core/psg_tone_noise_envelope_gen_macros.svh
// Assertion macros for the sound generator core.
// Included by the top-level core module to check its own logic; depends on nothing.
`ifndef PSG_TONE_NOISE_ENVELOPE_GEN_MACROS_SVH
`define PSG_TONE_NOISE_ENVELOPE_GEN_MACROS_SVH

`ifndef SYNTHESIS
`define PSGTNE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psgtne: same-cycle check failed");
`define PSGTNE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psgtne: next-cycle check failed");
`else
`define PSGTNE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSGTNE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/psgtne_pkg.sv
// Shared types and constants for the sound generator core.
// No dependencies; used by every module under rtl/core.
package psgtne_pkg;

    localparam int ENV_STEP_MASK_DEF = 31;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    localparam logic [3:0] REG_NOISE_PER  = 4'd6;
    localparam logic [3:0] REG_MIXER      = 4'd7;
    localparam logic [3:0] REG_VOL_A      = 4'd8;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;

    typedef struct packed {
        logic        tick;
        logic [11:0] period;
    } t_tone_ctl;

    typedef struct packed {
        logic       tick;
        logic [4:0] period;
    } t_noise_ctl;

    typedef struct packed {
        logic        tick;
        logic        restart;
        logic [3:0]  shape;
        logic [15:0] period;
    } t_env_ctl;

endpackage

FILE: rtl/core/psgtne_tone.sv
// One square-wave tone channel: 12-bit period counter and output toggle.
// Depends on psgtne_pkg.
module psgtne_tone (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  psgtne_pkg::t_tone_ctl i_ctl,
    output logic                  o_tone
);

    logic [11:0] r_cnt;
    logic [11:0] n_cnt;
    logic        r_tone;
    logic        n_tone;
    logic [12:0] cnt_inc;

    always_comb begin
        cnt_inc = {1'b0, r_cnt} + 13'd1;
        n_cnt   = r_cnt;
        n_tone  = r_tone;
        if (i_ctl.tick) begin
            if (cnt_inc >= {1'b0, i_ctl.period}) begin
                n_cnt  = '0;
                n_tone = ~r_tone;
            end else begin
                n_cnt = cnt_inc[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_tone <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_tone <= n_tone;
        end
    end

    assign o_tone = n_tone;

endmodule

FILE: rtl/core/psgtne_noise.sv
// Noise source: 5-bit period counter, divide-by-two prescaler, 17-bit LFSR.
// Depends on psgtne_pkg.
module psgtne_noise (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  psgtne_pkg::t_noise_ctl i_ctl,
    output logic                   o_noise
);

    logic [4:0]  r_cnt;
    logic [4:0]  n_cnt;
    logic        r_pre;
    logic        n_pre;
    logic [16:0] r_lfsr;
    logic [16:0] n_lfsr;
    logic [5:0]  cnt_inc;

    always_comb begin
        cnt_inc = {1'b0, r_cnt} + 6'd1;
        n_cnt   = r_cnt;
        n_pre   = r_pre;
        n_lfsr  = r_lfsr;
        if (i_ctl.tick) begin
            if (cnt_inc >= {1'b0, i_ctl.period}) begin
                n_cnt = '0;
                n_pre = ~r_pre;
                if (n_pre) begin
                    n_lfsr = {r_lfsr[0] ^ r_lfsr[3], r_lfsr[16:1]};
                end
            end else begin
                n_cnt = cnt_inc[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pre  <= 1'b0;
            r_lfsr <= 17'd1;
        end else begin
            r_cnt  <= n_cnt;
            r_pre  <= n_pre;
            r_lfsr <= n_lfsr;
        end
    end

    assign o_noise = n_lfsr[0];

endmodule

FILE: rtl/core/psgtne_env.sv
// Envelope generator: 16-bit period counter, step counter, attack/alternate/hold.
// Depends on psgtne_pkg.
module psgtne_env #(
    parameter int ENV_STEP_MASK = psgtne_pkg::ENV_STEP_MASK_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psgtne_pkg::t_env_ctl i_ctl,
    output logic [4:0]           o_env_vol
);

    localparam logic [5:0] STEP_MASK = 6'(ENV_STEP_MASK);
    localparam logic [5:0] STEP_TOP  = 6'(ENV_STEP_MASK + 1);
    localparam logic [4:0] ATK_MASK  = 5'(ENV_STEP_MASK);

    logic [15:0] r_cnt;
    logic [15:0] n_cnt;
    logic [5:0]  r_step;
    logic [5:0]  n_step;
    logic [4:0]  r_attack;
    logic [4:0]  n_attack;
    logic        r_hold;
    logic        n_hold;
    logic        r_alt;
    logic        n_alt;
    logic        r_holding;
    logic        n_holding;
    logic [16:0] cnt_inc;
    logic [5:0]  step_dec;

    always_comb begin
        cnt_inc   = {1'b0, r_cnt} + 17'd1;
        step_dec  = r_step - 6'd1;
        n_cnt     = r_cnt;
        n_step    = r_step;
        n_attack  = r_attack;
        n_hold    = r_hold;
        n_alt     = r_alt;
        n_holding = r_holding;
        if (i_ctl.restart) begin
            n_attack = i_ctl.shape[2] ? ATK_MASK : 5'd0;
            if (!i_ctl.shape[3]) begin
                n_hold = 1'b1;
                n_alt  = i_ctl.shape[2];
            end else begin
                n_hold = i_ctl.shape[0];
                n_alt  = i_ctl.shape[1];
            end
            n_step    = STEP_MASK;
            n_holding = 1'b0;
        end else if (i_ctl.tick && !r_holding) begin
            if (cnt_inc < {1'b0, i_ctl.period}) begin
                n_cnt = cnt_inc[15:0];
            end else begin
                n_cnt  = '0;
                n_step = step_dec;
                if (step_dec[5]) begin
                    if (r_hold) begin
                        if (r_alt) begin
                            n_attack = r_attack ^ ATK_MASK;
                        end
                        n_holding = 1'b1;
                        n_step    = '0;
                    end else begin
                        if (r_alt && ((step_dec & STEP_TOP) != 6'd0)) begin
                            n_attack = r_attack ^ ATK_MASK;
                        end
                        n_step = step_dec & STEP_MASK;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_step    <= '0;
            r_attack  <= '0;
            r_hold    <= 1'b0;
            r_alt     <= 1'b0;
            r_holding <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_step    <= n_step;
            r_attack  <= n_attack;
            r_hold    <= n_hold;
            r_alt     <= n_alt;
            r_holding <= n_holding;
        end
    end

    assign o_env_vol = n_step[4:0] ^ n_attack;

endmodule

FILE: rtl/core/psg_tone_noise_envelope_gen.sv
// Three-voice sound generator core: request register, register file, mixer, result register.
// A tick request passes from the request register to the result register; a write gives none.
// Throughput: one request (tick or write) per cycle;
// a tick waits while the result register holds an untaken result (o_m_tvalid/i_m_tready).
// Reset (i_rst_n low at a clock edge) clears the register file, all generator state and both
// handshake stages; no clearing pass. Depends on psgtne_pkg, the submodules and macro header.
`include "psg_tone_noise_envelope_gen_macros.svh"
module psg_tone_noise_envelope_gen #(
    parameter int ENV_STEP_MASK = psgtne_pkg::ENV_STEP_MASK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // reg_addr[3:0], reg_data[11:4], zero [15:12]
    input  logic [0:0]  i_s_tuser,  // command[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // level_a[4:0], level_b[9:5], level_c[14:10], noise_bit[15]
);

    logic               r_in_valid;
    psgtne_pkg::t_cmd   r_in_cmd;
    logic [3:0]         r_in_addr;
    logic [7:0]         r_in_data;
    logic [7:0]         r_regs [16];
    logic               r_out_valid;
    logic [15:0]        r_out_data;
    logic [15:0]        n_out_data;

    logic               out_free;
    logic               in_adv;
    logic               tick_fire;
    logic               wr_fire;
    logic [2:0]         tone;
    logic               noise;
    logic [4:0]         env_vol;
    logic [4:0]         level [3];
    psgtne_pkg::t_tone_ctl  tone_ctl [3];
    psgtne_pkg::t_noise_ctl noise_ctl;
    psgtne_pkg::t_env_ctl   env_ctl;

    assign out_free   = !r_out_valid || i_m_tready;
    assign in_adv     = r_in_valid && ((r_in_cmd == psgtne_pkg::CMD_WRITE) || out_free);
    assign tick_fire  = in_adv && (r_in_cmd == psgtne_pkg::CMD_TICK);
    assign wr_fire    = in_adv && (r_in_cmd == psgtne_pkg::CMD_WRITE);
    assign o_s_tready = !r_in_valid || in_adv;

    // hold the request until it advances; a tick waits until the result side can take it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (in_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_cmd  <= psgtne_pkg::t_cmd'(i_s_tuser[0]);
            r_in_addr <= i_s_tdata[3:0];
            r_in_data <= i_s_tdata[11:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_regs[i] <= '0;
            end
        end else if (wr_fire) begin
            r_regs[r_in_addr] <= r_in_data;
        end
    end

    assign noise_ctl.tick   = tick_fire;
    assign noise_ctl.period = r_regs[psgtne_pkg::REG_NOISE_PER][4:0];

    assign env_ctl.tick    = tick_fire;
    assign env_ctl.restart = wr_fire && (r_in_addr == psgtne_pkg::REG_ENV_SHAPE);
    assign env_ctl.shape   = r_in_data[3:0];
    assign env_ctl.period  = {r_regs[psgtne_pkg::REG_ENV_COARSE],
                              r_regs[psgtne_pkg::REG_ENV_FINE]};

    psgtne_noise u_noise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (noise_ctl),
        .o_noise (noise)
    );

    psgtne_env #(
        .ENV_STEP_MASK (ENV_STEP_MASK)
    ) u_env (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (env_ctl),
        .o_env_vol (env_vol)
    );

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic [7:0] vreg;
        logic       en;

        assign tone_ctl[ch].tick   = tick_fire;
        assign tone_ctl[ch].period = {r_regs[2*ch+1][3:0], r_regs[2*ch]};

        psgtne_tone u_tone (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (tone_ctl[ch]),
            .o_tone  (tone[ch])
        );

        assign vreg = r_regs[psgtne_pkg::REG_VOL_A + 4'(ch)];
        assign en   = (tone[ch] | r_regs[psgtne_pkg::REG_MIXER][ch])
                    & (noise | r_regs[psgtne_pkg::REG_MIXER][3+ch]);

        always_comb begin
            if (!en) begin
                level[ch] = '0;
            end else if (vreg[4]) begin
                level[ch] = env_vol;
            end else begin
                level[ch] = {vreg[3:0], 1'b0};
            end
        end
    end

    assign n_out_data = {noise, level[2], level[1], level[0]};

    // load a fresh result, drop a taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `PSGTNE_ASSERT_NXT(a_tick_gives_result, i_clk, i_rst_n, tick_fire, o_m_tvalid)
    `PSGTNE_ASSERT_NXT(a_write_no_result, i_clk, i_rst_n, wr_fire && o_m_tvalid && i_m_tready, !o_m_tvalid)
    `PSGTNE_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !o_s_tready, r_in_valid && !out_free)

endmodule
